// ----- hdl/lru_tile_cache_lookup_defines.svh -----
// assertion helpers for the tile cache lookup top level
`ifndef LRU_TILE_CACHE_LOOKUP_DEFINES_SVH
`define LRU_TILE_CACHE_LOOKUP_DEFINES_SVH

`ifndef ASSERT_OFF
`define LTC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define LTC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define LTC_ASSERT_ALWAYS(lbl, cond, msg)
`define LTC_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/ltc_pkg.sv -----
`timescale 1ns / 1ps

package ltc_pkg;

  localparam int SLOT_COUNT  = 8;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int USED_W      = $clog2(SLOT_COUNT + 1);
  localparam int IDX_W       = 16;
  localparam int EDGE_W      = IDX_W + 1;
  localparam int STEP_W      = $clog2(IDX_W);
  localparam int STAMP_W     = 64;
  localparam int OFS_W       = 32;
  localparam int LIMIT_W     = 4;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 4;
  // queue depth must stay a power of two, pointers wrap on their own
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [EDGE_W-1:0] EDGE_MAX = {1'b1, {IDX_W{1'b0}}};

  localparam logic [1:0] REG_MATRIX_SIZE = 2'd0;
  localparam logic [1:0] REG_TILE_EDGE   = 2'd1;
  localparam logic [1:0] REG_SLOT_LIMIT  = 2'd2;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_FILL    = 2'd1,
    ST_REPLACE = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_UPDATE,
    B_MULT,
    B_EMIT
  } back_state_t;

  // effective configuration, already clamped
  typedef struct packed {
    logic [EDGE_W-1:0] msize;
    logic [EDGE_W-1:0] tile_len;
    logic [USED_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic             range_err;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] rt;
    logic [IDX_W-1:0] ct;
    logic [IDX_W-1:0] lr;
    logic [IDX_W-1:0] lc;
  } entry_t;

endpackage

// ----- hdl/ltc_front.sv -----
`timescale 1ns / 1ps

module ltc_front (
  input  logic            clk,
  input  logic            rst,
  input  ltc_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [15:0]     req_row,
  input  logic [15:0]     req_col,
  output logic            q_valid,
  input  logic            q_ready,
  output ltc_pkg::entry_t q_data
);
  import ltc_pkg::*;

  front_state_t     state, state_next;
  logic [STEP_W-1:0] step;
  logic [IDX_W-1:0] row, col;
  logic [IDX_W-1:0] rquo, cquo;
  logic [IDX_W-1:0] rrem, crem;
  logic             range_err;

  logic [IDX_W:0]   r_trial, c_trial, r_diff, c_diff;
  logic             r_ge, c_ge;
  logic [IDX_W-1:0] r_rem_step, c_rem_step;

  // one restoring step per cycle for both indices
  assign r_trial    = {rrem, rquo[IDX_W-1]};
  assign c_trial    = {crem, cquo[IDX_W-1]};
  assign r_ge       = r_trial >= cfg.tile_len;
  assign c_ge       = c_trial >= cfg.tile_len;
  assign r_diff     = r_trial - cfg.tile_len;
  assign c_diff     = c_trial - cfg.tile_len;
  assign r_rem_step = r_ge ? r_diff[IDX_W-1:0] : r_trial[IDX_W-1:0];
  assign c_rem_step = c_ge ? c_diff[IDX_W-1:0] : c_trial[IDX_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (in_valid) begin
          if (({1'b0, req_row} >= cfg.msize) || ({1'b0, req_col} >= cfg.msize)) begin
            state_next = F_PUSH;
          end else begin
            state_next = F_DIV;
          end
        end
      end
      F_DIV: begin
        if (step == STEP_W'(IDX_W - 1)) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (q_ready) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = (state == F_IDLE);
    q_valid          = (state == F_PUSH);
    q_data.range_err = range_err;
    q_data.row       = row;
    q_data.col       = col;
    q_data.rt        = rquo;
    q_data.ct        = cquo;
    q_data.lr        = rrem;
    q_data.lc        = crem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) begin
      row       <= req_row;
      col       <= req_col;
      rquo      <= req_row;
      cquo      <= req_col;
      rrem      <= '0;
      crem      <= '0;
      step      <= '0;
      range_err <= ({1'b0, req_row} >= cfg.msize) || ({1'b0, req_col} >= cfg.msize);
    end else if (state == F_DIV) begin
      rquo <= {rquo[IDX_W-2:0], r_ge};
      cquo <= {cquo[IDX_W-2:0], c_ge};
      rrem <= r_rem_step;
      crem <= c_rem_step;
      step <= step + 1'b1;
    end
  end

endmodule

// ----- hdl/ltc_queue.sv -----
`timescale 1ns / 1ps

module ltc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ltc_pkg::entry_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ltc_pkg::entry_t out_data
);
  import ltc_pkg::*;

  entry_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push, pop;

  assign in_ready  = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

endmodule

// ----- hdl/ltc_back.sv -----
`timescale 1ns / 1ps

module ltc_back (
  input  logic                           clk,
  input  logic                           rst,
  input  ltc_pkg::cfg_t                  cfg,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  ltc_pkg::entry_t                q_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ltc_pkg::status_t               status,
  output logic [2:0]                     slot,
  output logic [15:0]                    row_tag,
  output logic [15:0]                    col_tag,
  output logic [15:0]                    ofs_row,
  output logic [15:0]                    ofs_col,
  output logic [16:0]                    tile_rows,
  output logic [16:0]                    tile_columns,
  output logic [31:0]                    tile_offset,
  output logic [ltc_pkg::USED_W-1:0]     used_slots
);
  import ltc_pkg::*;

  back_state_t       state, state_next;
  entry_t            cur;
  logic [USED_W-1:0] scan_idx;
  logic              found;
  logic [SLOT_W-1:0] hit_slot, victim;
  logic [STAMP_W-1:0] min_stamp;
  logic [STAMP_W-1:0] access_counter;
  logic [IDX_W-1:0]  tag_row_tile    [SLOT_COUNT];
  logic [IDX_W-1:0]  tag_column_tile [SLOT_COUNT];
  logic [STAMP_W-1:0] slot_stamp     [SLOT_COUNT];
  status_t           res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [EDGE_W-1:0] trows, tcols;
  logic [OFS_W-1:0]  product;

  logic [SLOT_W-1:0] sidx;
  logic              scan_done;
  logic              replace;
  logic [SLOT_W-1:0] upd_slot;
  status_t           upd_status;
  logic [IDX_W-1:0]  rbeg, cbeg;
  logic [EDGE_W:0]   rend_cand, cend_cand, rend, cend;
  logic [EDGE_W:0]   trows_wide, tcols_wide;
  logic [IDX_W+EDGE_W-1:0] mult_full;

  assign sidx      = scan_idx[SLOT_W-1:0];
  assign scan_done = found || (scan_idx == used_slots);
  assign replace   = (used_slots >= cfg.limit);

  always_comb begin
    priority if (found) begin
      upd_slot   = hit_slot;
      upd_status = ST_HIT;
    end else if (replace) begin
      upd_slot   = victim;
      upd_status = ST_REPLACE;
    end else begin
      upd_slot   = used_slots[SLOT_W-1:0];
      upd_status = ST_FILL;
    end
  end

  // tile bounds, clipped at the matrix edge
  always_comb begin
    rbeg       = cur.row - cur.lr;
    cbeg       = cur.col - cur.lc;
    rend_cand  = {2'b00, rbeg} + {1'b0, cfg.tile_len};
    cend_cand  = {2'b00, cbeg} + {1'b0, cfg.tile_len};
    rend       = (rend_cand < {1'b0, cfg.msize}) ? rend_cand : {1'b0, cfg.msize};
    cend       = (cend_cand < {1'b0, cfg.msize}) ? cend_cand : {1'b0, cfg.msize};
    trows_wide = rend - {2'b00, rbeg};
    tcols_wide = cend - {2'b00, cbeg};
    mult_full  = cur.lc * trows;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          state_next = q_data.range_err ? B_EMIT : B_SCAN;
        end
      end
      B_SCAN: begin
        if (scan_done) begin
          state_next = B_UPDATE;
        end
      end
      B_UPDATE: state_next = B_MULT;
      B_MULT:   state_next = B_EMIT;
      B_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state == B_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state that survives items
  always_ff @(posedge clk) begin
    if (rst) begin
      used_slots     <= '0;
      access_counter <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (state == B_UPDATE) begin
        // a miss spends one stamp on the build and one on the access
        access_counter <= access_counter + (found ? STAMP_W'(1) : STAMP_W'(2));
        if (!found && !replace) begin
          used_slots <= used_slots + 1'b1;
        end
      end
      if (state == B_EMIT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          cur      <= q_data;
          scan_idx <= '0;
          found    <= 1'b0;
          victim   <= '0;
        end
      end
      B_SCAN: begin
        if (!scan_done) begin
          if (tag_row_tile[sidx] == cur.rt && tag_column_tile[sidx] == cur.ct) begin
            found    <= 1'b1;
            hit_slot <= sidx;
          end
          // strict compare keeps the lowest slot on ties
          if (scan_idx == '0 || slot_stamp[sidx] < min_stamp) begin
            victim    <= sidx;
            min_stamp <= slot_stamp[sidx];
          end
          scan_idx <= scan_idx + 1'b1;
        end
      end
      B_UPDATE: begin
        res_status <= upd_status;
        res_slot   <= upd_slot;
        trows      <= trows_wide[EDGE_W-1:0];
        tcols      <= tcols_wide[EDGE_W-1:0];
        if (found) begin
          slot_stamp[upd_slot] <= access_counter + STAMP_W'(1);
        end else begin
          tag_row_tile[upd_slot]    <= cur.rt;
          tag_column_tile[upd_slot] <= cur.ct;
          slot_stamp[upd_slot]      <= access_counter + STAMP_W'(2);
        end
      end
      B_MULT: begin
        product <= mult_full[OFS_W-1:0];
      end
      B_EMIT: begin
        if (!out_valid || out_ready) begin
          if (cur.range_err) begin
            status       <= ST_RANGE;
            slot         <= '0;
            row_tag      <= '0;
            col_tag      <= '0;
            ofs_row      <= '0;
            ofs_col      <= '0;
            tile_rows    <= '0;
            tile_columns <= '0;
            tile_offset  <= '0;
          end else begin
            status       <= res_status;
            slot         <= res_slot;
            row_tag      <= cur.rt;
            col_tag      <= cur.ct;
            ofs_row      <= cur.lr;
            ofs_col      <= cur.lc;
            tile_rows    <= trows;
            tile_columns <= tcols;
            tile_offset  <= product + OFS_W'(cur.lr);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/lru_tile_cache_lookup.sv -----
`timescale 1ns / 1ps
// Tile lookup for a fully associative cache of matrix tiles with LRU replacement.
// Requests come in on a valid/ready channel (req_row, req_col); each
// transfer gives exactly one result transfer on the out_valid/out_ready channel
// with status, slot, tile tag, local offsets, clipped tile size and tile_offset.
// Configuration is written through the APB-style port; the user must write it
// only while the block is idle, which the block itself does not enforce:
// matrix_size at 0x0, tile_edge at 0x4, slots_in_use_limit at 0x8. The front
// part takes a request and divides both indices by the tile edge in a bit-serial
// divider; it takes no new request until the current one has gone into the
// queue. A two-entry queue feeds the back part, which scans the occupied slots
// one per cycle for the tag and the LRU victim, then updates the table and forms
// the offset with one multiply. An out-of-range request skips the divider and
// the back part's scan, update and multiply. Reset (synchronous, active high)
// empties the table, clears the stamp counter and loads the register defaults.
// When the receiver stalls, the result waits in the output register, the back
// part holds the next one, the queue fills and the front part holds in_ready low.
`include "lru_tile_cache_lookup_defines.svh"

module lru_tile_cache_lookup (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ltc_pkg::ADDR_W-1:0]     paddr,
  input  logic [ltc_pkg::DATA_W-1:0]     pwdata,
  output logic [ltc_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [15:0]                    req_row,
  input  logic [15:0]                    req_col,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ltc_pkg::status_t               status,
  output logic [2:0]                     slot,
  output logic [15:0]                    row_tag,
  output logic [15:0]                    col_tag,
  output logic [15:0]                    ofs_row,
  output logic [15:0]                    ofs_col,
  output logic [16:0]                    tile_rows,
  output logic [16:0]                    tile_columns,
  output logic [31:0]                    tile_offset
);
  import ltc_pkg::*;

  logic [EDGE_W-1:0]  matrix_size;
  logic [EDGE_W-1:0]  tile_edge;
  logic [LIMIT_W-1:0] slots_in_use_limit;
  logic [1:0]         reg_idx;
  logic               cfg_write;
  cfg_t               cfg;
  logic [EDGE_W-1:0]  edge_clamped;

  logic               fq_valid, fq_ready, qb_valid, qb_ready;
  entry_t             fq_data, qb_data;
  logic [USED_W-1:0]  used_slots;
  logic               res_data, res_range;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size        <= '0;
      tile_edge          <= EDGE_W'(256);
      slots_in_use_limit <= LIMIT_W'(4);
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_MATRIX_SIZE: matrix_size        <= pwdata[EDGE_W-1:0];
        REG_TILE_EDGE:   tile_edge          <= pwdata[EDGE_W-1:0];
        REG_SLOT_LIMIT:  slots_in_use_limit <= pwdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MATRIX_SIZE: prdata = DATA_W'(matrix_size);
      REG_TILE_EDGE:   prdata = DATA_W'(tile_edge);
      REG_SLOT_LIMIT:  prdata = DATA_W'(slots_in_use_limit);
      default:         prdata = '0;
    endcase
  end

  // clamp registers to their working ranges
  always_comb begin
    cfg.msize    = (matrix_size > EDGE_MAX) ? EDGE_MAX : matrix_size;
    edge_clamped = (tile_edge > EDGE_MAX) ? EDGE_MAX : tile_edge;
    cfg.tile_len = (edge_clamped == '0) ? EDGE_W'(1) : edge_clamped;
    priority if (slots_in_use_limit == '0) begin
      cfg.limit = USED_W'(1);
    end else if (int'(slots_in_use_limit) > SLOT_COUNT) begin
      cfg.limit = USED_W'(SLOT_COUNT);
    end else begin
      cfg.limit = USED_W'(slots_in_use_limit);
    end
  end

  ltc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_row      (req_row),
    .req_col      (req_col),
    .q_valid      (fq_valid),
    .q_ready      (fq_ready),
    .q_data       (fq_data)
  );

  ltc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  ltc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (qb_valid),
    .q_ready      (qb_ready),
    .q_data       (qb_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .slot         (slot),
    .row_tag      (row_tag),
    .col_tag      (col_tag),
    .ofs_row      (ofs_row),
    .ofs_col      (ofs_col),
    .tile_rows    (tile_rows),
    .tile_columns (tile_columns),
    .tile_offset  (tile_offset),
    .used_slots   (used_slots)
  );

  assign res_data  = out_valid && (status != ST_RANGE);
  assign res_range = out_valid && (status == ST_RANGE);

  `LTC_ASSERT_ALWAYS(a_used_bound, used_slots <= USED_W'(SLOT_COUNT), "occupancy above slot count")
  `LTC_ASSERT_IMPLY(a_slot_occupied, res_data, USED_W'(slot) < used_slots, "result slot not occupied")
  `LTC_ASSERT_IMPLY(a_range_zero, res_range, slot == '0 && tile_offset == '0, "range result not zero")
  `LTC_ASSERT_IMPLY(a_row_inside, res_data, EDGE_W'(ofs_row) < tile_rows, "row offset outside tile")
  `LTC_ASSERT_IMPLY(a_col_inside, res_data, EDGE_W'(ofs_col) < tile_columns, "col offset outside tile")

endmodule

// ----- test/tile_lookup_checker.sv -----
`timescale 1ns / 1ps

module tile_lookup_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [ltc_pkg::ADDR_W-1:0]   paddr,
  input  logic [ltc_pkg::DATA_W-1:0]   pwdata,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [15:0]                  req_row,
  input  logic [15:0]                  req_col,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  ltc_pkg::status_t             status,
  input  logic [2:0]                   slot,
  input  logic [15:0]                  row_tag,
  input  logic [15:0]                  col_tag,
  input  logic [15:0]                  ofs_row,
  input  logic [15:0]                  ofs_col,
  input  logic [16:0]                  tile_rows,
  input  logic [16:0]                  tile_columns,
  input  logic [31:0]                  tile_offset,
  output int                           failures,
  output int                           outstanding,
  output int                           checked
);
  import ltc_pkg::*;

  typedef struct {
    status_t     status;
    logic [2:0]  slot;
    logic [15:0] rt;
    logic [15:0] ct;
    logic [15:0] lr;
    logic [15:0] lc;
    logic [16:0] trows;
    logic [16:0] tcols;
    logic [31:0] ofs;
  } lookup_t;

  // register copies as written
  logic [16:0] matrix_size_reg;
  logic [16:0] tile_edge_reg;
  logic [3:0]  slot_limit_reg;

  // cache table
  int unsigned occupied;
  logic [15:0] held_rt [SLOT_COUNT];
  logic [15:0] held_ct [SLOT_COUNT];
  logic [63:0] held_stamp [SLOT_COUNT];
  logic [63:0] stamp_clock;

  lookup_t pending_lookups [$];

  function automatic lookup_t predict_lookup(input logic [15:0] row, input logic [15:0] col);
    lookup_t     r;
    int unsigned msz, tedge, lim, i, hit_slot, rt, ct, rbeg, cbeg, rend, cend, trows, tcols;
    int unsigned lr, lc;
    bit          found;
    logic [63:0] ofs;
    r.status = ST_RANGE;
    r.slot = '0;
    r.rt = '0;
    r.ct = '0;
    r.lr = '0;
    r.lc = '0;
    r.trows = '0;
    r.tcols = '0;
    r.ofs = '0;
    msz = (matrix_size_reg > EDGE_MAX) ? EDGE_MAX : matrix_size_reg;
    tedge = (tile_edge_reg > EDGE_MAX) ? EDGE_MAX : tile_edge_reg;
    if (tedge == 0) tedge = 1;
    lim = (slot_limit_reg == 0) ? 1 : slot_limit_reg;
    if (lim > SLOT_COUNT) lim = SLOT_COUNT;
    if (row >= msz || col >= msz) return r;

    rt = row / tedge;
    ct = col / tedge;
    found = 0;
    hit_slot = 0;
    for (i = 0; i < occupied; i++) begin
      if (!found && held_rt[i] == rt[15:0] && held_ct[i] == ct[15:0]) begin
        found = 1;
        hit_slot = i;
      end
    end

    if (found) begin
      r.status = ST_HIT;
    end else begin
      // a miss spends one stamp on building the tile
      stamp_clock++;
      if (occupied >= lim) begin
        hit_slot = 0;
        for (i = 1; i < occupied; i++) begin
          if (held_stamp[i] < held_stamp[hit_slot]) hit_slot = i;
        end
        r.status = ST_REPLACE;
      end else begin
        hit_slot = occupied;
        occupied++;
        r.status = ST_FILL;
      end
      held_rt[hit_slot] = rt[15:0];
      held_ct[hit_slot] = ct[15:0];
    end
    stamp_clock++;
    held_stamp[hit_slot] = stamp_clock;

    rbeg = rt * tedge;
    cbeg = ct * tedge;
    rend = (rbeg + tedge < msz) ? rbeg + tedge : msz;
    cend = (cbeg + tedge < msz) ? cbeg + tedge : msz;
    trows = rend - rbeg;
    tcols = cend - cbeg;
    lr = row - rbeg;
    lc = col - cbeg;
    ofs = 64'(lr) + 64'(lc) * 64'(trows);

    r.slot = hit_slot[2:0];
    r.rt = rt[15:0];
    r.ct = ct[15:0];
    r.lr = lr[15:0];
    r.lc = lc[15:0];
    r.trows = trows[16:0];
    r.tcols = tcols[16:0];
    r.ofs = ofs[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    if (rst) begin
      matrix_size_reg = '0;
      tile_edge_reg = 17'd256;
      slot_limit_reg = 4'd4;
      occupied = 0;
      stamp_clock = '0;
      pending_lookups.delete();
      failures = 0;
      checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_lookups.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result transfer with no lookup pending", $realtime);
        end else begin
          want = pending_lookups.pop_front();
          checked++;
          if (status !== want.status || slot !== want.slot || row_tag !== want.rt ||
              col_tag !== want.ct || ofs_row !== want.lr || ofs_col !== want.lc ||
              tile_rows !== want.trows || tile_columns !== want.tcols ||
              tile_offset !== want.ofs) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: lookup mismatch, expected status %0d slot %0d tile %0d,%0d",
                       $realtime, want.status, want.slot, want.rt, want.ct);
              $display("  local %0d,%0d size %0dx%0d offset %0d", want.lr, want.lc,
                       want.trows, want.tcols, want.ofs);
              $display("  got status %0d slot %0d tile %0d,%0d local %0d,%0d", status,
                       slot, row_tag, col_tag, ofs_row, ofs_col);
              $display("  size %0dx%0d offset %0d", tile_rows, tile_columns, tile_offset);
            end
          end
        end
      end
      if (in_valid && in_ready)
        pending_lookups.insert(pending_lookups.size(), predict_lookup(req_row, req_col));
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MATRIX_SIZE: matrix_size_reg = pwdata[16:0];
          REG_TILE_EDGE:   tile_edge_reg = pwdata[16:0];
          REG_SLOT_LIMIT:  slot_limit_reg = pwdata[3:0];
          default: ;
        endcase
      end
    end
    outstanding = pending_lookups.size();
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import ltc_pkg::*;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [15:0]         req_row;
  logic [15:0]         req_col;
  logic                out_valid;
  logic                out_ready;
  status_t             status;
  logic [2:0]          slot;
  logic [15:0]         row_tag;
  logic [15:0]         col_tag;
  logic [15:0]         ofs_row;
  logic [15:0]         ofs_col;
  logic [16:0]         tile_rows;
  logic [16:0]         tile_columns;
  logic [31:0]         tile_offset;

  int failures;
  int outstanding;
  int checked;

  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_req;
  int          requests_sent;
  int          config_count;
  int unsigned phase_size;
  int unsigned phase_edge;
  int unsigned pool_n;
  int unsigned pool_rt [12];
  int unsigned pool_ct [12];

  lru_tile_cache_lookup dut (.*);

  tile_lookup_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic setup_lookup(input int unsigned size_val, input int unsigned edge_val,
                              input int unsigned limit_val);
    int unsigned lim, tiles, k;
    write_reg(REG_MATRIX_SIZE, size_val);
    write_reg(REG_TILE_EDGE, edge_val);
    write_reg(REG_SLOT_LIMIT, limit_val);
    config_count++;
    // tile pool of the slot limit plus up to three tiles, so hits and evictions mix
    phase_size = (size_val > 65536) ? 65536 : size_val;
    phase_edge = (edge_val > 65536) ? 65536 : ((edge_val == 0) ? 1 : edge_val);
    lim = (limit_val == 0) ? 1 : ((limit_val > SLOT_COUNT) ? SLOT_COUNT : limit_val);
    pool_n = lim + $urandom_range(3);
    tiles = (phase_size + phase_edge - 1) / phase_edge;
    for (k = 0; k < pool_n; k++) begin
      pool_rt[k] = (tiles == 0) ? 0 : $urandom_range(tiles - 1);
      pool_ct[k] = (tiles == 0) ? 0 : $urandom_range(tiles - 1);
    end
  endtask

  task automatic send_request(input logic [15:0] row, input logic [15:0] col);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    req_row = row;
    req_col = col;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (outstanding == 0);
  endtask

  task automatic pick_request(output logic [15:0] row, output logic [15:0] col);
    int unsigned k, base_r, base_c, span_r, span_c;
    if (phase_size == 0 || $urandom_range(99) < 15) begin
      row = 16'($urandom);
      col = 16'($urandom);
    end else begin
      k = $urandom_range(pool_n - 1);
      base_r = pool_rt[k] * phase_edge;
      base_c = pool_ct[k] * phase_edge;
      span_r = (phase_size - base_r < phase_edge) ? phase_size - base_r : phase_edge;
      span_c = (phase_size - base_c < phase_edge) ? phase_size - base_c : phase_edge;
      row = 16'(base_r + $urandom_range(span_r - 1));
      col = 16'(base_c + $urandom_range(span_c - 1));
    end
  endtask

  initial begin
    int          ph;
    int          n;
    int          i;
    logic [15:0] r;
    logic [15:0] c;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    req_row = '0;
    req_col = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    requests_sent = 0;
    config_count = 0;
    phase_size = 0;
    phase_edge = 256;
    pool_n = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty matrix after reset: everything is out of range
    send_request(16'd0, 16'd0);
    send_request(16'hffff, 16'hffff);
    drain();

    // two slots, clipped last tile, each index out of range in turn
    setup_lookup(1050, 100, 2);
    send_request(16'd0, 16'd0);
    send_request(16'd99, 16'd99);
    send_request(16'd1049, 16'd1049);
    send_request(16'd150, 16'd5);
    send_request(16'd1050, 16'd0);
    send_request(16'd0, 16'd1050);
    send_request(16'd0, 16'd0);
    drain();

    // limit below occupancy
    write_reg(REG_SLOT_LIMIT, 1);
    send_request(16'd500, 16'd500);
    send_request(16'd0, 16'd0);
    drain();

    // oversized matrix, zero edge, zero limit
    setup_lookup(32'h1ffff, 0, 0);
    send_request(16'hffff, 16'hffff);
    send_request(16'd0, 16'd0);
    send_request(16'hffff, 16'd0);
    drain();

    // one tile covering the whole matrix, largest offset
    setup_lookup(65536, 65536, 15);
    send_request(16'hffff, 16'hffff);
    send_request(16'd0, 16'd0);
    drain();

    setup_lookup(65536, 32'h1ffff, 8);
    send_request(16'd12345, 16'd54321);
    drain();

    // fill all eight slots, then one eviction
    setup_lookup(256, 32, 8);
    for (i = 0; i < 9; i++)
      send_request(16'((i % 8) * 32), 16'((i / 8) * 32 + 31));
    drain();

    for (ph = 0; ph < 12; ph++) begin
      case (ph)
        0: setup_lookup(2000, 64, 4);
        1: setup_lookup(65536, 4096, 8);
        2: setup_lookup(300, 7, 1);
        3: setup_lookup(65536, 1, 8);
        4: setup_lookup(5000, 65536, 3);
        5: setup_lookup(32'h1ffff, 32'h10001, 0);
        default: setup_lookup($urandom_range(1) ? $urandom_range(4000, 1)
                                                : $urandom_range(131071, 1),
                              ($urandom_range(3) != 0) ? $urandom_range(200, 1)
                                                       : $urandom_range(131071),
                              $urandom_range(15));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (n = 0; n < 108; n++) begin
        // long receiver hold-off while requests keep coming
        if (ph == 4 && n == 20) hold_req = 1;
        if (ph == 6 && n == 54) drain();
        pick_request(r, c);
        send_request(r, c);
      end
      drain();
    end

    repeat (40) @(posedge clk);
    $display("covered %0d lookup requests over %0d configurations, %0d results compared",
             requests_sent, config_count, checked);
    $display("idle and stall mixes varied per phase, with one long result hold-off");
    if (failures == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
